// ===== src/modular_exponentiation_core_assert.svh =====
// Assertion macros shared by the modular exponentiation core modules.
`ifndef MODULAR_EXPONENTIATION_CORE_ASSERT_SVH
`define MODULAR_EXPONENTIATION_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define MEXP_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define MEXP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/mexp_pkg.sv =====
// Shared widths, constants and control types of the modular exponentiation core.
package mexp_pkg;

    localparam int BASE_W    = 63;
    localparam int EXP_W     = 63;
    localparam int RES_W     = 30;
    localparam int PROD_W    = 61;
    localparam int QUOT_W    = 32;
    localparam int M_W       = 33;
    localparam int BIT_CNT_W = 6;

    localparam logic [RES_W-1:0]     PRIME     = 30'd1000000007;
    localparam logic [RES_W-1:0]     FOLD_30   = 30'd73741817;
    localparam logic [M_W-1:0]       BARRETT_M = 33'd4611685986;
    localparam logic [QUOT_W-1:0]    PRIME_X1  = 32'd1000000007;
    localparam logic [QUOT_W-1:0]    PRIME_X2  = 32'd2000000014;
    localparam logic [QUOT_W-1:0]    PRIME_X3  = 32'd3000000021;
    localparam logic [BIT_CNT_W-1:0] LAST_BIT  = 6'd62;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_EST,
        ST_QP,
        ST_SUB,
        ST_FIX,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        OP_REDUCE,
        OP_SQUARE,
        OP_MULT
    } op_t;

    typedef struct packed {
        logic load;
        op_t  op;
        logic fix;
        logic shift_exp;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic exp_msb;
        logic out_free;
    } status_t;

endpackage

// ===== src/mexp_in_if.sv =====
// Input channel: base and exponent word with valid/ready handshake.
interface mexp_in_if;

    logic                         valid;
    logic                         ready;
    logic [mexp_pkg::BASE_W-1:0] base_value;
    logic [mexp_pkg::EXP_W-1:0]  exponent_value;

    modport source (output valid, output base_value, output exponent_value, input ready);
    modport sink (input valid, input base_value, input exponent_value, output ready);

endinterface

// ===== src/mexp_out_if.sv =====
// Output channel: power residue word with valid/ready handshake.
interface mexp_out_if;

    logic                        valid;
    logic                        ready;
    logic [mexp_pkg::RES_W-1:0] power_residue;

    modport source (output valid, output power_residue, input ready);
    modport sink (input valid, input power_residue, output ready);

endinterface

// ===== src/mexp_ctrl.sv =====
// Sequencer for reduce, square and multiply rounds over the exponent bits.
`include "modular_exponentiation_core_assert.svh"

module mexp_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output mexp_pkg::cmd_t    cmd,
    input  mexp_pkg::status_t status
);

    mexp_pkg::state_t                   state_reg;
    mexp_pkg::state_t                   state_next;
    mexp_pkg::op_t                      op_reg;
    mexp_pkg::op_t                      op_next;
    logic [mexp_pkg::BIT_CNT_W-1:0]     bit_cnt_reg;
    logic [mexp_pkg::BIT_CNT_W-1:0]     bit_cnt_next;
    logic                               bit_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= mexp_pkg::ST_IDLE;
            op_reg      <= mexp_pkg::OP_REDUCE;
            bit_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            op_reg      <= op_next;
            bit_cnt_reg <= bit_cnt_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        bit_cnt_next = bit_cnt_reg;
        in_ready     = 1'b0;
        bit_done     = 1'b0;
        cmd          = '0;
        cmd.op       = op_reg;
        unique case (state_reg)
            mexp_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load     = 1'b1;
                    op_next      = mexp_pkg::OP_REDUCE;
                    bit_cnt_next = mexp_pkg::LAST_BIT;
                    state_next   = mexp_pkg::ST_MUL;
                end
            end
            mexp_pkg::ST_MUL: state_next = mexp_pkg::ST_EST;
            mexp_pkg::ST_EST: state_next = mexp_pkg::ST_QP;
            mexp_pkg::ST_QP:  state_next = mexp_pkg::ST_SUB;
            mexp_pkg::ST_SUB: state_next = mexp_pkg::ST_FIX;
            mexp_pkg::ST_FIX:
            begin
                cmd.fix    = 1'b1;
                state_next = mexp_pkg::ST_MUL;
                unique case (op_reg)
                    mexp_pkg::OP_REDUCE: op_next = mexp_pkg::OP_SQUARE;
                    mexp_pkg::OP_SQUARE:
                    begin
                        if (status.exp_msb)
                        begin
                            op_next = mexp_pkg::OP_MULT;
                        end
                        else
                        begin
                            bit_done = 1'b1;
                        end
                    end
                    default: bit_done = 1'b1;
                endcase
                if (bit_done)
                begin
                    cmd.shift_exp = 1'b1;
                    op_next       = mexp_pkg::OP_SQUARE;
                    if (bit_cnt_reg == '0)
                    begin
                        state_next = mexp_pkg::ST_DONE;
                    end
                    else
                    begin
                        bit_cnt_next = bit_cnt_reg - 1'b1;
                    end
                end
            end
            mexp_pkg::ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = mexp_pkg::ST_IDLE;
                end
            end
            default: state_next = mexp_pkg::ST_IDLE;
        endcase
    end

    `MEXP_ASSERT_NEXT(a_accept_starts_reduce, in_valid && in_ready, state_reg == mexp_pkg::ST_MUL && op_reg == mexp_pkg::OP_REDUCE, "accepted word did not start base reduction")
    `MEXP_ASSERT_NEXT(a_last_bit_finishes, state_reg == mexp_pkg::ST_FIX && op_reg == mexp_pkg::OP_SQUARE && !status.exp_msb && bit_cnt_reg == '0, state_reg == mexp_pkg::ST_DONE, "last exponent bit did not finish")
    `MEXP_ASSERT_IMPL(a_busy_not_ready, state_reg != mexp_pkg::ST_IDLE, !in_ready && !cmd.load, "input taken while busy")

endmodule

// ===== src/mexp_datapath.sv =====
// Operand registers and the shared multiply with Barrett reduction modulo the prime.
`include "modular_exponentiation_core_assert.svh"

module mexp_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [mexp_pkg::BASE_W-1:0]   base_value,
    input  logic [mexp_pkg::EXP_W-1:0]    exponent_value,
    input  mexp_pkg::cmd_t                cmd,
    output mexp_pkg::status_t             status,
    mexp_out_if.source                    result
);

    logic [mexp_pkg::BASE_W-1:0]  base_reg;
    logic [mexp_pkg::EXP_W-1:0]   exp_reg;
    logic [mexp_pkg::RES_W-1:0]   acc_reg;
    logic [mexp_pkg::PROD_W-1:0]  prod_reg;
    logic [mexp_pkg::QUOT_W-1:0]  quot_reg;
    logic [mexp_pkg::QUOT_W-1:0]  qp_reg;
    logic [mexp_pkg::QUOT_W-1:0]  diff_reg;
    logic [mexp_pkg::RES_W-1:0]   residue_reg;
    logic                         valid_reg;

    logic [32:0]                  mul_a;
    logic [mexp_pkg::RES_W-1:0]   mul_b;
    logic [mexp_pkg::RES_W-1:0]   mul_add;
    logic [62:0]                  prod_full;
    logic [65:0]                  est_full;
    logic [61:0]                  qp_full;
    logic [mexp_pkg::QUOT_W-1:0]  corrected;
    logic [mexp_pkg::RES_W-1:0]   reduced;

    always_comb
    begin
        case (cmd.op)
            mexp_pkg::OP_REDUCE:
            begin
                mul_a   = base_reg[62:30];
                mul_b   = mexp_pkg::FOLD_30;
                mul_add = base_reg[29:0];
            end
            mexp_pkg::OP_SQUARE:
            begin
                mul_a   = {3'b0, acc_reg};
                mul_b   = acc_reg;
                mul_add = '0;
            end
            default:
            begin
                mul_a   = {3'b0, acc_reg};
                mul_b   = base_reg[29:0];
                mul_add = '0;
            end
        endcase
    end

    assign prod_full = {30'b0, mul_a} * {33'b0, mul_b} + {33'b0, mul_add};
    assign est_full  = {33'b0, prod_reg[60:28]} * {33'b0, mexp_pkg::BARRETT_M};
    assign qp_full   = {30'b0, quot_reg} * {32'b0, mexp_pkg::PRIME};

    always_comb
    begin
        if (diff_reg >= mexp_pkg::PRIME_X2)
        begin
            corrected = diff_reg - mexp_pkg::PRIME_X2;
        end
        else if (diff_reg >= mexp_pkg::PRIME_X1)
        begin
            corrected = diff_reg - mexp_pkg::PRIME_X1;
        end
        else
        begin
            corrected = diff_reg;
        end
        reduced = corrected[29:0];
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_full[60:0];
        quot_reg <= est_full[65:34];
        qp_reg   <= qp_full[31:0];
        diff_reg <= prod_reg[31:0] - qp_reg;
        if (cmd.load)
        begin
            base_reg <= base_value;
            exp_reg  <= exponent_value;
            acc_reg  <= 30'd1;
        end
        else
        begin
            if (cmd.fix)
            begin
                if (cmd.op == mexp_pkg::OP_REDUCE)
                begin
                    base_reg <= {33'b0, reduced};
                end
                else
                begin
                    acc_reg <= reduced;
                end
            end
            if (cmd.shift_exp)
            begin
                exp_reg <= {exp_reg[61:0], 1'b0};
            end
        end
        if (cmd.emit)
        begin
            residue_reg <= acc_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    assign status.exp_msb  = exp_reg[62];
    assign status.out_free = !valid_reg || result.ready;

    assign result.valid         = valid_reg;
    assign result.power_residue = residue_reg;

    `MEXP_ASSERT_IMPL(a_quotient_error, cmd.fix, diff_reg < mexp_pkg::PRIME_X3, "quotient estimate off by more than two")
    `MEXP_ASSERT_NEXT(a_emit_holds_acc, cmd.emit, result.valid && result.power_residue == $past(acc_reg), "result word lost accumulator value")
    `MEXP_ASSERT_IMPL(a_result_reduced, result.valid, result.power_residue < mexp_pkg::PRIME, "result word not reduced")

endmodule

// ===== src/modular_exponentiation_core.sv =====
// Computes base to the exponent modulo 1000000007, one word at a time. After a word is
// accepted the core reduces the base, then walks all 63 exponent bits from the top: a
// square every bit, plus a multiply by the reduced base for each one bit. Every modular
// multiply passes through one shared unit (product, Barrett quotient estimate, quotient
// times prime, subtract, final correction). The result sits in an output register, and
// the next word is taken while it waits.
module modular_exponentiation_core (
    input  logic       clk,
    input  logic       rst_n,
    mexp_in_if.sink    operand,
    mexp_out_if.source result
);

    mexp_pkg::cmd_t    cmd;
    mexp_pkg::status_t status;

    mexp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (operand.valid),
        .in_ready (operand.ready),
        .cmd      (cmd),
        .status   (status)
    );

    mexp_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .base_value     (operand.base_value),
        .exponent_value (operand.exponent_value),
        .cmd            (cmd),
        .status         (status),
        .result         (result)
    );

endmodule
